// File: rtl/iotfs_pkg.sv
// iotfs_pkg: shared widths, reset constants, request kinds and the
// controller/datapath command and status structs of the footprint statistics block.
// No dependencies.
package iotfs_pkg;

  // Field widths of one request and one result
  localparam int START_W = 32;
  localparam int LEN_W   = 16;
  localparam int COUNT_W = 32;
  localparam int SUM_W   = 48;
  localparam int POS_W   = 33;
  localparam int UNIQ_W  = 21;

  // Parameter defaults
  localparam int DEF_MAP_ADDRESS_BITS = 20;
  localparam int DEF_MARK_STRIDE      = 8;
  localparam int DEF_WORD_BITS        = 32;

  localparam logic [START_W-1:0] MIN_START_RESET = 32'h7FFF_FFFF;

  // Request direction codes
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic clear;    // zero one word of both maps
    logic load;     // take the request and update the per-request totals
    logic drop;     // count a mark outside the map and step to the next mark
    logic rd;       // read the word that holds the current mark
    logic wr;       // set the mark bit and step to the next mark
    logic publish;  // copy the running totals into the result register
  } iotfs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at the last word
    logic done;        // no mark left below the request end
    logic out_of_map;  // current mark lies at or above the map size
  } iotfs_stat_t;

endpackage

// File: rtl/io_trace_footprint_stats_top.sv
// io_trace_footprint_stats_top: storage request footprint statistics, top level.
// Instantiates iotfs_ctrl and iotfs_dp; depends on iotfs_pkg.
//
// Channel   Handshake            Payload
// input     in_valid / in_ready  kind, start_sector, length_sectors
// output    out_valid/ out_ready write_requests, read_requests, total_sectors,
//                                lowest_start, highest_end, distinct_written,
//                                distinct_read, dropped_marks
//
// Each request walks M marks inside the map and D beyond it, M + D =
// ceil(length_sectors / MARK_STRIDE); each in-map mark reads, then tests and writes,
// the single-port bitmap word.
// Reset: rst clears all totals, then a clearing pass zeroes both bitmaps one word per
// cycle, 2**MAP_ADDRESS_BITS / word-size words (32768 by default), in_ready low.
// Stalls: a held result lets the next request be accepted and walked; only its publish waits.
module io_trace_footprint_stats_top #(
  parameter int MAP_ADDRESS_BITS = iotfs_pkg::DEF_MAP_ADDRESS_BITS,
  parameter int MARK_STRIDE      = iotfs_pkg::DEF_MARK_STRIDE,
  parameter int WORD_BITS        = iotfs_pkg::DEF_WORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [iotfs_pkg::START_W-1:0] start_sector,
  input  logic [iotfs_pkg::LEN_W-1:0]   length_sectors,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [iotfs_pkg::COUNT_W-1:0] write_requests,
  output logic [iotfs_pkg::COUNT_W-1:0] read_requests,
  output logic [iotfs_pkg::SUM_W-1:0]   total_sectors,
  output logic [iotfs_pkg::START_W-1:0] lowest_start,
  output logic [iotfs_pkg::POS_W-1:0]   highest_end,
  output logic [iotfs_pkg::UNIQ_W-1:0]  distinct_written,
  output logic [iotfs_pkg::UNIQ_W-1:0]  distinct_read,
  output logic [iotfs_pkg::COUNT_W-1:0] dropped_marks
);
  import iotfs_pkg::*;

  // Command and status between sequencer and datapath
  iotfs_cmd_t  cmd;
  iotfs_stat_t stat;

  // Sequencer: clear pass, mark loop, request handshakes
  iotfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: bitmaps, walker, totals, result register
  iotfs_dp #(
    .MAP_ADDRESS_BITS (MAP_ADDRESS_BITS),
    .MARK_STRIDE      (MARK_STRIDE),
    .WORD_BITS        (WORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .kind             (kind),
    .start_sector     (start_sector),
    .length_sectors   (length_sectors),
    .write_requests   (write_requests),
    .read_requests    (read_requests),
    .total_sectors    (total_sectors),
    .lowest_start     (lowest_start),
    .highest_end      (highest_end),
    .distinct_written (distinct_written),
    .distinct_read    (distinct_read),
    .dropped_marks    (dropped_marks)
  );

endmodule

// File: rtl/iotfs_ctrl.sv
// iotfs_ctrl: sequencer of the footprint statistics block.
// Runs the clearing pass, the per-mark read-modify-write and the result handshake.
// Depends on iotfs_pkg.
module iotfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  iotfs_pkg::iotfs_stat_t stat,
  output iotfs_pkg::iotfs_cmd_t  cmd
);
  import iotfs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK,
    S_WRITE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MARK;
        end
      end
      S_MARK: begin
        if (stat.done) begin
          state_next = S_DONE;
        end else if (stat.out_of_map) begin
          cmd.drop = 1'b1;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr     = 1'b1;
        state_next = S_MARK;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/iotfs_dp.sv
// iotfs_dp: datapath of the footprint statistics block: both footprint maps,
// the mark walker, the running totals and the result register.
// Depends on iotfs_pkg.
module iotfs_dp #(
  parameter int MAP_ADDRESS_BITS = iotfs_pkg::DEF_MAP_ADDRESS_BITS,
  parameter int MARK_STRIDE      = iotfs_pkg::DEF_MARK_STRIDE,
  parameter int WORD_BITS        = iotfs_pkg::DEF_WORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  iotfs_pkg::iotfs_cmd_t         cmd,
  output iotfs_pkg::iotfs_stat_t        stat,
  input  logic                          kind,
  input  logic [iotfs_pkg::START_W-1:0] start_sector,
  input  logic [iotfs_pkg::LEN_W-1:0]   length_sectors,
  output logic [iotfs_pkg::COUNT_W-1:0] write_requests,
  output logic [iotfs_pkg::COUNT_W-1:0] read_requests,
  output logic [iotfs_pkg::SUM_W-1:0]   total_sectors,
  output logic [iotfs_pkg::START_W-1:0] lowest_start,
  output logic [iotfs_pkg::POS_W-1:0]   highest_end,
  output logic [iotfs_pkg::UNIQ_W-1:0]  distinct_written,
  output logic [iotfs_pkg::UNIQ_W-1:0]  distinct_read,
  output logic [iotfs_pkg::COUNT_W-1:0] dropped_marks
);
  import iotfs_pkg::*;

  // Storage word: largest power of two not above WORD_BITS, so that a mark
  // position splits into word address and bit index by plain bit fields.
  localparam int SLOT_BITS  = 2 ** ($clog2(WORD_BITS + 1) - 1);
  localparam int SLOT_IDX_W = $clog2(SLOT_BITS);
  localparam int WADDR_W    = MAP_ADDRESS_BITS - SLOT_IDX_W;
  localparam int MAP_WORDS  = 2 ** WADDR_W;

  logic [SLOT_BITS-1:0] wmap [MAP_WORDS];
  logic [SLOT_BITS-1:0] rmap [MAP_WORDS];
  logic [SLOT_BITS-1:0] wmap_q;
  logic [SLOT_BITS-1:0] rmap_q;

  logic [WADDR_W-1:0] clr_addr;
  logic [WADDR_W-1:0] mem_addr;
  logic [SLOT_IDX_W-1:0] bit_idx;
  logic [SLOT_BITS-1:0] cur_word;
  logic [SLOT_BITS-1:0] set_word;
  logic                 bit_clear;

  logic               kind_q;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   end_q;
  logic [POS_W-1:0]   end_next;
  logic [POS_W-1:0]   pos_step;

  logic [COUNT_W-1:0] write_count;
  logic [COUNT_W-1:0] read_count;
  logic [SUM_W-1:0]   size_sum;
  logic [SUM_W:0]     size_ext;
  logic [START_W-1:0] min_start;
  logic [POS_W-1:0]   max_end;
  logic [UNIQ_W-1:0]  unique_written;
  logic [UNIQ_W-1:0]  unique_read;
  logic [COUNT_W-1:0] drop_count;

  assign end_next = {1'b0, start_sector} + POS_W'(length_sectors);
  assign size_ext = {1'b0, size_sum} + (SUM_W + 1)'(length_sectors);
  assign pos_step = pos + POS_W'(MARK_STRIDE);

  assign bit_idx   = pos[SLOT_IDX_W-1:0];
  assign mem_addr  = cmd.clear ? clr_addr : pos[MAP_ADDRESS_BITS-1:SLOT_IDX_W];
  assign cur_word  = (kind_q == KIND_READ) ? rmap_q : wmap_q;
  assign bit_clear = !cur_word[bit_idx];
  assign set_word  = cur_word | (SLOT_BITS'(1) << bit_idx);

  assign stat.clear_last = &clr_addr;
  assign stat.done       = (pos >= end_q);
  assign stat.out_of_map = |pos[POS_W-1:MAP_ADDRESS_BITS];

  // Footprint maps: single port each, registered read
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      wmap[mem_addr] <= '0;
    end else if (cmd.wr && kind_q == KIND_WRITE) begin
      wmap[mem_addr] <= set_word;
    end
    if (cmd.rd) begin
      wmap_q <= wmap[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      rmap[mem_addr] <= '0;
    end else if (cmd.wr && kind_q == KIND_READ) begin
      rmap[mem_addr] <= set_word;
    end
    if (cmd.rd) begin
      rmap_q <= rmap[mem_addr];
    end
  end

  // Request registers and mark walker
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      pos    <= {1'b0, start_sector};
      end_q  <= end_next;
    end else if (cmd.drop || cmd.wr) begin
      pos <= pos_step;
    end
  end

  // Running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr       <= '0;
      write_count    <= '0;
      read_count     <= '0;
      size_sum       <= '0;
      min_start      <= MIN_START_RESET;
      max_end        <= '0;
      unique_written <= '0;
      unique_read    <= '0;
      drop_count     <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + WADDR_W'(1);
      end
      if (cmd.load) begin
        if (kind == KIND_READ) begin
          if (read_count != '1) begin
            read_count <= read_count + COUNT_W'(1);
          end
        end else if (write_count != '1) begin
          write_count <= write_count + COUNT_W'(1);
        end
        size_sum <= size_ext[SUM_W] ? '1 : size_ext[SUM_W-1:0];
        if (start_sector < min_start) begin
          min_start <= start_sector;
        end
        if (end_next > max_end) begin
          max_end <= end_next;
        end
      end
      if (cmd.drop && drop_count != '1) begin
        drop_count <= drop_count + COUNT_W'(1);
      end
      if (cmd.wr && bit_clear) begin
        if (kind_q == KIND_READ) begin
          if (unique_read != '1) begin
            unique_read <= unique_read + UNIQ_W'(1);
          end
        end else if (unique_written != '1) begin
          unique_written <= unique_written + UNIQ_W'(1);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      write_requests   <= write_count;
      read_requests    <= read_count;
      total_sectors    <= size_sum;
      lowest_start     <= min_start;
      highest_end      <= max_end;
      distinct_written <= unique_written;
      distinct_read    <= unique_read;
      dropped_marks    <= drop_count;
    end
  end

endmodule

// File: rtl/iotfs_check.sv
// iotfs_check: port-level checks of the footprint statistics block, and the
// bind that attaches them to io_trace_footprint_stats_top. Depends on iotfs_pkg.
module iotfs_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [iotfs_pkg::COUNT_W-1:0] write_requests,
  input logic [iotfs_pkg::COUNT_W-1:0] read_requests,
  input logic [iotfs_pkg::SUM_W-1:0]   total_sectors,
  input logic [iotfs_pkg::START_W-1:0] lowest_start,
  input logic [iotfs_pkg::POS_W-1:0]   highest_end
);
  import iotfs_pkg::*;

  // Reset starts the clearing pass: no request taken, no result shown
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("request accepted or result shown right after reset");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(write_requests) &&
      $stable(read_requests) && $stable(total_sectors))
    else $error("stalled result changed");

  // Every result follows at least one request
  a_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (write_requests != '0) || (read_requests != '0))
    else $error("result with no request counted");

  // Lowest start never rises above its reset value
  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lowest_start <= MIN_START_RESET)
    else $error("lowest start above reset value");

  // Highest end covers the lowest start once a request has been seen
  a_end_cover: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> highest_end >= {1'b0, lowest_start})
    else $error("highest end below lowest start");

endmodule

bind io_trace_footprint_stats_top iotfs_check u_check (.*);

// File: tb/iotfs_footprint_checker.sv
// iotfs_footprint_checker: watches both channels of the footprint statistics block,
// keeps its own footprint maps and running totals, and checks every result.
// Depends on iotfs_pkg.
module iotfs_footprint_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          kind,
  input  logic [iotfs_pkg::START_W-1:0] start_sector,
  input  logic [iotfs_pkg::LEN_W-1:0]   length_sectors,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [iotfs_pkg::COUNT_W-1:0] write_requests,
  input  logic [iotfs_pkg::COUNT_W-1:0] read_requests,
  input  logic [iotfs_pkg::SUM_W-1:0]   total_sectors,
  input  logic [iotfs_pkg::START_W-1:0] lowest_start,
  input  logic [iotfs_pkg::POS_W-1:0]   highest_end,
  input  logic [iotfs_pkg::UNIQ_W-1:0]  distinct_written,
  input  logic [iotfs_pkg::UNIQ_W-1:0]  distinct_read,
  input  logic [iotfs_pkg::COUNT_W-1:0] dropped_marks,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import iotfs_pkg::*;

  localparam int MAP_WORDS = (2 ** DEF_MAP_ADDRESS_BITS) / DEF_WORD_BITS;
  localparam logic [POS_W-1:0] MAP_LIMIT = POS_W'(1) << DEF_MAP_ADDRESS_BITS;

  typedef struct packed {
    logic [COUNT_W-1:0] writes;
    logic [COUNT_W-1:0] reads;
    logic [SUM_W-1:0]   sectors;
    logic [START_W-1:0] low_start;
    logic [POS_W-1:0]   high_end;
    logic [UNIQ_W-1:0]  written_uniq;
    logic [UNIQ_W-1:0]  read_uniq;
    logic [COUNT_W-1:0] drops;
  } totals_t;

  logic [DEF_WORD_BITS-1:0] write_footprint [MAP_WORDS];
  logic [DEF_WORD_BITS-1:0] read_footprint  [MAP_WORDS];
  totals_t                  running;
  totals_t                  expected_totals [$];
  int                       fail_tally = 0;

  // Apply one request to the model state and return the totals it should report.
  function automatic totals_t tally_request(input logic dir,
                                            input logic [START_W-1:0] first,
                                            input logic [LEN_W-1:0] span);
    logic [POS_W-1:0] stop_pos;
    logic [POS_W-1:0] pos;
    logic [SUM_W:0]   sum;
    int unsigned      word_idx;
    int unsigned      bit_idx;
    stop_pos = {1'b0, first} + POS_W'(span);
    if (dir == KIND_READ) begin
      if (running.reads != '1) running.reads++;
    end else begin
      if (running.writes != '1) running.writes++;
    end
    for (pos = {1'b0, first}; pos < stop_pos; pos += POS_W'(DEF_MARK_STRIDE)) begin
      if (pos >= MAP_LIMIT) begin
        if (running.drops != '1) running.drops++;
      end else begin
        word_idx = int'(pos) / DEF_WORD_BITS;
        bit_idx  = int'(pos) % DEF_WORD_BITS;
        if (dir == KIND_READ) begin
          if (!read_footprint[word_idx][bit_idx]) begin
            read_footprint[word_idx][bit_idx] = 1'b1;
            if (running.read_uniq != '1) running.read_uniq++;
          end
        end else begin
          if (!write_footprint[word_idx][bit_idx]) begin
            write_footprint[word_idx][bit_idx] = 1'b1;
            if (running.written_uniq != '1) running.written_uniq++;
          end
        end
      end
    end
    if (stop_pos > running.high_end) running.high_end = stop_pos;
    if (first < running.low_start) running.low_start = first;
    sum = {1'b0, running.sectors} + (SUM_W + 1)'(span);
    running.sectors = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
    return running;
  endfunction

  function automatic void compare_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      fail_tally++;
    end
  endfunction

  always @(posedge clk) begin : watch
    totals_t want;
    if (rst) begin
      foreach (write_footprint[i]) write_footprint[i] = '0;
      foreach (read_footprint[i]) read_footprint[i] = '0;
      running = '0;
      running.low_start = MIN_START_RESET;
      expected_totals.delete();
    end else begin
      // Check the result first so a stray one is never paired with a new request.
      if (out_valid && out_ready) begin
        if (expected_totals.size() == 0) begin
          $display("%0t: result with no request waiting, expected none actual writes %0d",
                   $time, write_requests);
          fail_tally++;
        end else begin
          want = expected_totals.pop_front();
          compare_field("write_requests", want.writes, write_requests);
          compare_field("read_requests", want.reads, read_requests);
          compare_field("total_sectors", want.sectors, total_sectors);
          compare_field("lowest_start", want.low_start, lowest_start);
          compare_field("highest_end", want.high_end, highest_end);
          compare_field("distinct_written", want.written_uniq, distinct_written);
          compare_field("distinct_read", want.read_uniq, distinct_read);
          compare_field("dropped_marks", want.drops, dropped_marks);
        end
      end
      if (in_valid && in_ready)
        expected_totals.push_back(tally_request(kind, start_sector, length_sectors));
    end
    mismatches  <= fail_tally;
    outstanding <= expected_totals.size();
  end

endmodule

// File: tb/io_trace_footprint_stats_top_tb.sv
// io_trace_footprint_stats_top_tb: stimulus and verdict for the footprint statistics
// block; checking is done by iotfs_footprint_checker. Depends on iotfs_pkg and the RTL.
module io_trace_footprint_stats_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iotfs_pkg::*;

  // End of the bitmap as a sector number; marks at or above it are dropped.
  localparam logic [START_W-1:0] MAP_END = START_W'(1) << DEF_MAP_ADDRESS_BITS;
  localparam int RANDOM_REQUESTS = 1836;
  // Cycles without any handshake before the run is declared hung. The slowest
  // legitimate quiet spell is the clearing pass after reset; a maximum-length
  // request and the long output hold are both shorter.
  localparam int STALL_LIMIT  = 200000;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 40;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                kind;
  logic [START_W-1:0]  start_sector;
  logic [LEN_W-1:0]    length_sectors;
  logic                out_valid;
  logic                out_ready;
  logic [COUNT_W-1:0]  write_requests;
  logic [COUNT_W-1:0]  read_requests;
  logic [SUM_W-1:0]    total_sectors;
  logic [START_W-1:0]  lowest_start;
  logic [POS_W-1:0]    highest_end;
  logic [UNIQ_W-1:0]   distinct_written;
  logic [UNIQ_W-1:0]   distinct_read;
  logic [COUNT_W-1:0]  dropped_marks;
  int                  mismatches;
  int                  outstanding;
  int                  burst_left = 0;
  int                  results_taken = 0;
  int                  stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  io_trace_footprint_stats_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .start_sector     (start_sector),
    .length_sectors   (length_sectors),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .write_requests   (write_requests),
    .read_requests    (read_requests),
    .total_sectors    (total_sectors),
    .lowest_start     (lowest_start),
    .highest_end      (highest_end),
    .distinct_written (distinct_written),
    .distinct_read    (distinct_read),
    .dropped_marks    (dropped_marks)
  );

  iotfs_footprint_checker checker_inst (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .start_sector     (start_sector),
    .length_sectors   (length_sectors),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .write_requests   (write_requests),
    .read_requests    (read_requests),
    .total_sectors    (total_sectors),
    .lowest_start     (lowest_start),
    .highest_end      (highest_end),
    .distinct_written (distinct_written),
    .distinct_read    (distinct_read),
    .dropped_marks    (dropped_marks),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // Offer one request and hold it until the block takes it, then idle for a
  // random gap. Valid is lowered only when a gap follows, so back-to-back
  // requests keep valid high without a second assignment in the same step.
  task automatic send_request(input logic dir, input logic [START_W-1:0] first,
                              input logic [LEN_W-1:0] span);
    int gap;
    in_valid       <= 1'b1;
    kind           <= dir;
    start_sector   <= first;
    length_sectors <= span;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 99);
      // Now and then run a stretch of requests with no idle cycles at all.
      if (gap < 4) burst_left = 40;
      if (gap < 55) gap = 0;
      else if (gap < 92) gap = $urandom_range(1, 4);
      else gap = $urandom_range(15, 80);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Count results taken; the output side uses this to place its long hold.
  always @(posedge clk) begin
    if (out_valid && out_ready) results_taken <= results_taken + 1;
  end

  // Watchdog: end the run if no request and no result moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("io_trace_footprint_stats_top_tb: errors");
      $finish;
    end
  end

  // Output side: random runs of ready high and low. Once, after a few hundred
  // results, hold ready low long enough that the block fills its result
  // register, walks the next request and then stalls its input.
  initial begin : result_sink
    int  pick;
    int  run;
    bit  held;
    out_ready = 1'b0;
    held      = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_taken >= 300) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          out_ready <= 1'b1;
          run = 200;
        end else if (pick < 60) begin
          out_ready <= 1'b1;
          run = $urandom_range(1, 12);
        end else if (pick < 93) begin
          out_ready <= 1'b0;
          run = $urandom_range(1, 4);
        end else begin
          out_ready <= 1'b0;
          run = $urandom_range(20, 90);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : request_source
    logic [START_W-1:0] first;
    logic [LEN_W-1:0]   span;
    int                 pick;
    rst            = 1'b1;
    in_valid       = 1'b0;
    kind           = KIND_WRITE;
    start_sector   = '0;
    length_sectors = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Start with requests above the reset minimum so that
    // lowest_start must hold its reset value through them.
    send_request(KIND_WRITE, 32'hFFFF_FFFF, 16'd0);      // zero length, top start
    send_request(KIND_READ,  32'h8000_0000, 16'd17);     // every mark beyond the map
    send_request(KIND_WRITE, 32'hFFFF_FFFF, 16'hFFFF);   // largest end, many drops
    send_request(KIND_READ,  32'h7FFF_FFFF, 16'd1);      // equal to reset minimum
    send_request(KIND_WRITE, 32'h7FFF_FFFE, 16'd0);      // just below it
    send_request(KIND_WRITE, 32'd0, 16'd1);              // first map bit
    send_request(KIND_WRITE, 32'd0, 16'd8);              // same bit again, no new sector
    send_request(KIND_WRITE, 32'd1, 16'd9);              // two marks, stride apart
    send_request(KIND_READ,  32'd0, 16'hFFFF);           // longest walk inside the map
    send_request(KIND_READ,  32'd3, 16'hFFFF);
    send_request(KIND_WRITE, MAP_END - 32'd16, 16'd48);  // straddle the map end
    send_request(KIND_READ,  MAP_END - 32'd1, 16'd2);    // last map bit
    send_request(KIND_WRITE, MAP_END, 16'd8);            // first position past the map
    send_request(KIND_READ,  32'h5555_5555, 16'hAAAA);
    send_request(KIND_WRITE, 32'hAAAA_AAAA, 16'h5555);
    send_request(KIND_READ,  32'd256, 16'd0);

    // Random part: mostly a dense region so marks hit already-set bits, then
    // the whole map, the map end, and the full start range. Lengths are mostly
    // short; a few are long and a rare one spans all sixteen bits.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) first = START_W'($urandom_range(0, 16383));
      else if (pick < 80) first = START_W'($urandom_range(0, int'(MAP_END) - 1));
      else if (pick < 90) first = MAP_END - START_W'($urandom_range(1, 600));
      else first = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 5) span = '0;
      else if (pick < 93) span = LEN_W'($urandom_range(1, 320));
      else if (pick < 99) span = LEN_W'($urandom_range(321, 2048));
      else span = LEN_W'($urandom());
      send_request(1'($urandom_range(0, 1)), first, span);
    end
    in_valid <= 1'b0;

    // The checker's count is registered; let it catch up before trusting it.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("io_trace_footprint_stats_top_tb: clean");
    else $display("io_trace_footprint_stats_top_tb: errors");
    $finish;
  end

endmodule
